// ----- rtl/core/sidt_pkg.sv -----
// Package for the signed integer to decimal text core.
// Holds the BCD digit type and the ASCII constants. No dependencies.
package sidt_pkg;

  localparam int NUM_DIGITS  = 10;
  localparam int VALUE_W     = 32;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int STEP_COUNT  = VALUE_W / 2;
  localparam int STEP_CNT_W  = $clog2(STEP_COUNT);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

endpackage

// ----- rtl/core/signed_int_to_decimal_text_core.sv -----
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Steps: accept, conversion (two bits per pass of one shared
// shift-and-add-3 unit), scan, then one character per cycle while out_ready is high.
// Emits 1..11 characters per value; not ready for a new value while busy.
// Reset: synchronous, active high; returns to idle with no character pending.
// Depends on sidt_pkg and sidt_dabble_step.
module signed_int_to_decimal_text_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         character,
  output logic               last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                               state;
  logic                                 neg;
  logic [sidt_pkg::VALUE_W-1:0]         mag;
  sidt_pkg::bcd_t                       bcd;
  sidt_pkg::bcd_t                       bcd_next;
  logic [sidt_pkg::STEP_CNT_W-1:0]      cnt;
  logic [sidt_pkg::DIGIT_IDX_W-1:0]     ptr;
  logic [sidt_pkg::DIGIT_IDX_W-1:0]     lead;

  sidt_dabble_step u_step (
    .bcd_in  (bcd),
    .bits_in (mag[sidt_pkg::VALUE_W-1 -: 2]),
    .bcd_out (bcd_next)
  );

  always_comb begin
    lead = '0;
    for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        lead = sidt_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg   <= value[31];
            mag   <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
            bcd   <= '0;
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          bcd <= bcd_next;
          mag <= {mag[sidt_pkg::VALUE_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == sidt_pkg::STEP_CNT_W'(sidt_pkg::STEP_COUNT - 1)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          out_valid <= 1'b1;
          if (neg) begin
            character <= sidt_pkg::ASCII_MINUS;
            last      <= 1'b0;
            ptr       <= lead;
          end else begin
            character <= sidt_pkg::ASCII_ZERO + {4'd0, bcd[lead]};
            last      <= (lead == '0);
            ptr       <= lead - 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              character <= sidt_pkg::ASCII_ZERO + {4'd0, bcd[ptr]};
              last      <= (ptr == '0);
              ptr       <= ptr - 1'b1;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("output pending while idle");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("not idle after final character");

  a_conv_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> !out_valid && !in_ready)
    else $error("handshake active during conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == sidt_pkg::ASCII_MINUS) |-> !last)
    else $error("minus sign marked as final character");

endmodule

// ----- rtl/core/sidt_dabble_step.sv -----
// Shift-and-add-3 step of the binary to BCD converter, two bits per call.
// Depends on sidt_pkg.
module sidt_dabble_step (
  input  sidt_pkg::bcd_t bcd_in,
  input  logic [1:0]     bits_in,
  output sidt_pkg::bcd_t bcd_out
);

  sidt_pkg::bcd_t           stage_a;
  sidt_pkg::bcd_t           stage_b;
  logic [4*sidt_pkg::NUM_DIGITS:0] shifted_a;
  logic [4*sidt_pkg::NUM_DIGITS:0] shifted_b;

  always_comb begin
    stage_a = bcd_in;
    for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
      if (stage_a[i] >= 4'd5) begin
        stage_a[i] = stage_a[i] + 4'd3;
      end
    end
    shifted_a = {stage_a, bits_in[1]};
    stage_b = shifted_a[4*sidt_pkg::NUM_DIGITS-1:0];
    for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
      if (stage_b[i] >= 4'd5) begin
        stage_b[i] = stage_b[i] + 4'd3;
      end
    end
    shifted_b = {stage_b, bits_in[0]};
    bcd_out = shifted_b[4*sidt_pkg::NUM_DIGITS-1:0];
  end

endmodule
